### hw/rtl/polyphonic_square_tone_mixer_assert.svh
// Assertion macros used by the checker of the tone mixer.
// The macros expect signals named clk_i and rst_ni in the scope where they are used.
`ifndef POLYPHONIC_SQUARE_TONE_MIXER_ASSERT_SVH
`define POLYPHONIC_SQUARE_TONE_MIXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold after a delay of dly following the antecedent.
`define PSM_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

### hw/rtl/psm_pkg.sv
// Package of the polyphonic square tone mixer: sizes, token type and period ROM.
// Used by the interfaces, the cell, the top level and the checker; depends on nothing.
package psm_pkg;

  // Voice count and phase format.
  localparam int VOICE_COUNT     = 25;
  localparam int PHASE_FRAC_BITS = 8;
  localparam int PHASE_W         = 16;
  localparam int INPUT_BITS      = 25;
  localparam int SAMPLE_W        = 6;

  // Running sum wide enough for every voice to add one step.
  localparam int SUM_W = $clog2(VOICE_COUNT + 1) + 1;

  // Delay from an accepted word to the result showing at the output.
  localparam int PSM_LATENCY = VOICE_COUNT + 1;

  // Equal-tempered period ROM construction constants.
  localparam int          CENTER_INDEX = 21;
  localparam logic [63:0] RATIO_NUM    = 64'd1059463;
  localparam logic [63:0] RATIO_DEN    = 64'd1000000;

  localparam logic [PHASE_W:0] PHASE_STEP = (PHASE_W + 1)'(1) << PHASE_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] SUM_UP   = SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SUM_DOWN = '1;
  localparam logic signed [SUM_W-1:0] SUM_ZERO = '0;

  localparam logic signed [SUM_W+SAMPLE_W:0] SAMPLE_HI = (SUM_W + SAMPLE_W + 1)'(31);
  localparam logic signed [SUM_W+SAMPLE_W:0] SAMPLE_LO = -(SUM_W + SAMPLE_W + 1)'(32);

  // Largest magnitude a result can reach with the voices that have an input bit.
  localparam int SOUNDING = (VOICE_COUNT < INPUT_BITS) ? VOICE_COUNT : INPUT_BITS;
  localparam int SAMPLE_MAX_INT = (SOUNDING > 31) ? 31 : SOUNDING;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(SAMPLE_MAX_INT);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -SAMPLE_W'(SAMPLE_MAX_INT);

  // Token handed from cell to cell along the chain.
  typedef struct packed {
    logic                    valid;
    logic [INPUT_BITS-1:0]   mask;
    logic signed [SUM_W-1:0] sum;
  } psm_tok_t;

  typedef logic [VOICE_COUNT-1:0][PHASE_W-1:0] period_rom_t;

  // Period of one voice in Q8.8, built from a Q.32 value by rounded semitone steps.
  function automatic logic [PHASE_W-1:0] period_fixed(int idx);
    logic [63:0] p;
    logic [63:0] r;
    p = ((64'd32000 << 32) + 64'd220) / 64'd440;
    if (idx < CENTER_INDEX) begin
      for (int k = idx; k < CENTER_INDEX; k++) begin
        p = (p * RATIO_NUM + RATIO_DEN / 64'd2) / RATIO_DEN;
      end
    end else begin
      for (int k = CENTER_INDEX; k < idx; k++) begin
        p = (p * RATIO_DEN + RATIO_NUM / 64'd2) / RATIO_NUM;
      end
    end
    r = (p + (64'd1 << (31 - PHASE_FRAC_BITS))) >> (32 - PHASE_FRAC_BITS);
    if (r > 64'hFFFF) begin
      r = 64'hFFFF;
    end
    return r[PHASE_W-1:0];
  endfunction

  function automatic period_rom_t build_period_rom();
    period_rom_t rom;
    for (int j = 0; j < VOICE_COUNT; j++) begin
      rom[j] = period_fixed(j);
    end
    return rom;
  endfunction

  localparam period_rom_t VOICE_PERIOD = build_period_rom();

  // Clamp the running sum to the signed sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(logic signed [SUM_W-1:0] s);
    logic signed [SUM_W+SAMPLE_W:0] e;
    logic signed [SAMPLE_W-1:0]     r;
    e = (SUM_W + SAMPLE_W + 1)'(s);
    if (e > SAMPLE_HI) begin
      r = SAMPLE_HI[SAMPLE_W-1:0];
    end else if (e < SAMPLE_LO) begin
      r = SAMPLE_LO[SAMPLE_W-1:0];
    end else begin
      r = e[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/psm_ifs.sv
// Valid/ready channel interfaces of the tone mixer: tick words in, samples out.
// Depends on psm_pkg for the payload widths.
interface psm_tick_if;
  import psm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INPUT_BITS-1:0] voices_on_mask;
  modport source (output valid, output voices_on_mask, input ready);
  modport sink (input valid, input voices_on_mask, output ready);
endinterface

interface psm_sample_if;
  import psm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  modport source (output valid, output mixed_sample, input ready);
  modport sink (input valid, input mixed_sample, output ready);
endinterface

### hw/rtl/psm_cell.sv
// One voice cell of the mixer chain: holds the voice phase and adds its level.
// Depends on psm_pkg for the token type and phase format.
module psm_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [psm_pkg::PHASE_W-1:0]    period_i,
  input  psm_pkg::psm_tok_t              tok_i,
  output psm_pkg::psm_tok_t              tok_o
);
  import psm_pkg::*;

  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic                  valid_q;
  logic [INPUT_BITS-1:0] mask_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                  active;
  logic                  level_high;
  logic [PHASE_W:0]      phase_inc;
  logic [PHASE_W:0]      phase_wrap;

  // The voice sounds when the token passes and its mask bit is set.
  assign active = tok_i.valid && tok_i.mask[0];

  // Level from the phase before the advance, then advance and wrap.
  always_comb begin
    level_high = ({phase_q, 1'b0} > {1'b0, period_i});
    phase_inc  = {1'b0, phase_q} + PHASE_STEP;
    if (phase_inc > {1'b0, period_i}) begin
      phase_wrap = phase_inc - {1'b0, period_i};
    end else begin
      phase_wrap = phase_inc;
    end
    phase_d = active ? phase_wrap[PHASE_W-1:0] : phase_q;
    sum_d   = active ? (tok_i.sum + (level_high ? SUM_UP : SUM_DOWN)) : tok_i.sum;
  end

  // Phase state and token valid are cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= tok_i.valid;
    end
  end

  // Token payload moves on to the next cell with the mask shifted down.
  always_ff @(posedge clk_i) begin
    mask_q <= tok_i.mask >> 1;
    sum_q  <= sum_d;
  end

  assign tok_o = '{valid: valid_q, mask: mask_q, sum: sum_q};

endmodule

### hw/rtl/polyphonic_square_tone_mixer.sv
// Polyphonic square tone mixer: each accepted tick word walks a chain of voice cells,
// one cell per voice and one cell per cycle, and the sum leaves through an output
// register. A new word is taken once the previous sample has left or is leaving, so
// one word is in flight at a time.
module polyphonic_square_tone_mixer (
  input  logic         clk_i,
  input  logic         rst_ni,
  psm_tick_if.sink     tick_i,
  psm_sample_if.source sample_o
);
  import psm_pkg::*;

  psm_tok_t tok [VOICE_COUNT+1];

  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic in_accept;
  logic out_taken;

  // A word is taken when the chain is empty and the output is free or draining.
  assign out_taken    = out_valid_q && sample_o.ready;
  assign tick_i.ready = !busy_q && (!out_valid_q || sample_o.ready);
  assign in_accept    = tick_i.valid && tick_i.ready;

  // Chain head: the accepted word starts with a zero sum.
  assign tok[0] = '{valid: in_accept, mask: tick_i.voices_on_mask, sum: SUM_ZERO};

  // One cell per voice, each handing the token to its neighbor.
  for (genvar j = 0; j < VOICE_COUNT; j++) begin : g_cell
    psm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .period_i (VOICE_PERIOD[j]),
      .tok_i    (tok[j]),
      .tok_o    (tok[j+1])
    );
  end

  // Busy from acceptance until the token leaves the last cell; output valid until taken.
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (in_accept) begin
      busy_d = 1'b1;
    end else if (tok[VOICE_COUNT].valid) begin
      busy_d = 1'b0;
    end
    if (tok[VOICE_COUNT].valid) begin
      out_valid_d = 1'b1;
    end else if (out_taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register holds the clamped sum.
  always_ff @(posedge clk_i) begin
    if (tok[VOICE_COUNT].valid) begin
      sample_q <= sat_sample(tok[VOICE_COUNT].sum);
    end
  end

  assign sample_o.valid        = out_valid_q;
  assign sample_o.mixed_sample = sample_q;

endmodule

### hw/rtl/psm_checker.sv
// Port checker of the tone mixer and the bind that attaches it to the top level.
// Depends on psm_pkg and the assertion macro header.
`include "polyphonic_square_tone_mixer_assert.svh"

module psm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic [psm_pkg::INPUT_BITS-1:0]      in_mask_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [psm_pkg::SAMPLE_W-1:0] out_sample_i
);
  import psm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled sample blocks new tick words.
  `PSM_ASSERT_SAME(a_stall_blocks_in, out_valid_i && !out_ready_i, !in_ready_i, "word taken while sample stalled")

  // The output register is empty right after a word is taken.
  `PSM_ASSERT_NEXT(a_out_empty_after_in, in_acc, !out_valid_i, "sample shown too early")

  // Every word yields its sample after the chain latency.
  `PSM_ASSERT_DELAY(a_latency, in_acc, PSM_LATENCY, out_valid_i, "sample missing after chain latency")

  // A word with no voices gives a silent sample.
  `PSM_ASSERT_DELAY(a_silent, in_acc && (in_mask_i == '0), PSM_LATENCY, out_sample_i == '0, "silent word gave nonzero sample")

  // Samples stay within the reachable range.
  `PSM_ASSERT_SAME(a_range, out_valid_i, (out_sample_i <= SAMPLE_MAX) && (out_sample_i >= SAMPLE_MIN), "sample out of range")

endmodule

bind polyphonic_square_tone_mixer psm_checker u_psm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (tick_i.valid),
  .in_ready_i   (tick_i.ready),
  .in_mask_i    (tick_i.voices_on_mask),
  .out_valid_i  (sample_o.valid),
  .out_ready_i  (sample_o.ready),
  .out_sample_i (sample_o.mixed_sample)
);
